// ----- src/pbr_pkg.sv -----
// Shared types and constants for the PCG32 bounded random unit.
package pbr_pkg;

  localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;

  localparam int unsigned STATE_W = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LIMIT_W = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned XSH_SHIFT = 18;
  localparam int unsigned XSH_LO = 27;
  localparam int unsigned ROT_LO = 59;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT = 1'd1;

  typedef enum logic [1:0] {
    KIND_DIV  = 2'd0,
    KIND_PASS = 2'd1,
    KIND_ERR  = 2'd2
  } draw_kind_t;

  typedef struct packed {
    draw_kind_t        kind;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] divisor;
  } draw_entry_t;

endpackage

// ----- src/pbr_front.sv -----
// Front end: accepts draw requests, forms the output word, classifies the limit and steps the LCG.
module pbr_front
  import pbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [LIMIT_W-1:0]    in_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output draw_entry_t           q_entry
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_MUL  = 2'b10
  } front_state_t;

  localparam logic [1:0] LCG_LAST_STEP = 2'd3;

  front_state_t         state_r, state_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [STATE_W-1:0]   gen_state_r, gen_state_nxt;
  logic [STATE_W-1:0]   increment_r, increment_nxt;
  logic [STATE_W-1:0]   acc_r, acc_nxt;
  logic [2*WORD_W-1:0]  prod_r;
  logic [WORD_W-1:0]    mul_a, mul_b;
  logic [STATE_W-1:0]   xs;
  logic [WORD_W-1:0]    x_word;
  logic [4:0]           rot;
  logic [2*WORD_W-1:0]  rot_wide;

  assign in_tready = (state_r == F_IDLE) && !q_full;
  assign q_push = in_tvalid && in_tready;

  always_comb begin
    xs = gen_state_r ^ (gen_state_r >> XSH_SHIFT);
    x_word = xs[XSH_LO +: WORD_W];
    rot = gen_state_r[ROT_LO +: 5];
    rot_wide = {x_word, x_word} >> rot;
    q_entry.word = rot_wide[WORD_W-1:0];
    q_entry.divisor = in_tdata[WORD_W-1:0];
    if (in_tdata == '0) begin
      q_entry.kind = KIND_ERR;
    end else if (|in_tdata[LIMIT_W-1:WORD_W]) begin
      q_entry.kind = KIND_PASS;
    end else begin
      q_entry.kind = KIND_DIV;
    end
  end

  always_comb begin
    mul_a = (state_r == F_MUL && step_r == 2'd1) ? gen_state_r[STATE_W-1:WORD_W]
                                                 : gen_state_r[WORD_W-1:0];
    mul_b = (state_r == F_MUL && step_r == 2'd0) ? PCG_MULT[STATE_W-1:WORD_W]
                                                 : PCG_MULT[WORD_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    gen_state_nxt = gen_state_r;
    increment_nxt = increment_r;
    acc_nxt = acc_r;
    unique case (state_r)
      F_IDLE: begin
        if (cfg_we && cfg_index == REG_SEED) begin
          gen_state_nxt = cfg_wdata;
        end
        if (cfg_we && cfg_index == REG_INCREMENT) begin
          increment_nxt = cfg_wdata;
        end
        if (q_push) begin
          state_nxt = F_MUL;
          step_nxt = 2'd0;
        end
      end
      F_MUL: begin
        step_nxt = step_r + 2'd1;
        unique case (step_r)
          2'd0: acc_nxt = prod_r;
          2'd1, 2'd2: acc_nxt = acc_r + {prod_r[WORD_W-1:0], {WORD_W{1'b0}}};
          default: begin
            gen_state_nxt = acc_r + {increment_r[STATE_W-1:1], 1'b1};
            state_nxt = F_IDLE;
          end
        endcase
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r <= 2'd0;
      gen_state_r <= '0;
      increment_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      gen_state_r <= gen_state_nxt;
      increment_r <= increment_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    prod_r <= mul_a * mul_b;
  end

  a_no_accept_while_stepping: assert property (
    @(posedge clk) disable iff (!rst_n) state_r == F_MUL |-> !in_tready)
    else $error("front accepted a transaction during the LCG step");

  a_step_returns_idle: assert property (
    @(posedge clk) disable iff (!rst_n)
    state_r == F_MUL && step_r == LCG_LAST_STEP |=> state_r == F_IDLE)
    else $error("LCG sequence did not finish after its last step");

  a_push_starts_step: assert property (
    @(posedge clk) disable iff (!rst_n)
    q_push |=> state_r == F_MUL && step_r == 2'd0)
    else $error("accepted transaction did not start the LCG step");

endmodule

// ----- src/pbr_queue.sv -----
// Short queue of classified draws between the front end and the remainder unit.
module pbr_queue
  import pbr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  draw_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output draw_entry_t head_entry,
  output logic        empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  draw_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (
    @(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (
    @(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");

  a_count_bound: assert property (
    @(posedge clk) disable iff (!rst_n) count_r <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule

// ----- src/pbr_back.sv -----
// Back end: bit-serial remainder unit and output register for the draw results.
module pbr_back
  import pbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  draw_entry_t       q_entry,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,
  output logic              out_tuser
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  localparam int unsigned CNT_W = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] div_r, div_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic              err_r, err_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [WORD_W-1:0] out_tdata_r, out_tdata_nxt;
  logic              out_tuser_r, out_tuser_nxt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   trial_diff;
  logic [WORD_W-1:0] rem_step;
  logic              out_free;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
  assign out_free = !out_tvalid_r || out_tready;
  assign q_pop = (state_r == B_IDLE) && !q_empty;

  always_comb begin
    trial = {rem_r, quo_r[WORD_W-1]};
    trial_diff = trial - {1'b0, div_r};
    rem_step = trial_diff[WORD_W] ? trial[WORD_W-1:0] : trial_diff[WORD_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    res_nxt = res_r;
    err_nxt = err_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          unique case (q_entry.kind)
            KIND_DIV: begin
              rem_nxt = '0;
              quo_nxt = q_entry.word;
              div_nxt = q_entry.divisor;
              cnt_nxt = '0;
              state_nxt = B_DIV;
            end
            KIND_PASS: begin
              res_nxt = q_entry.word;
              err_nxt = 1'b0;
              state_nxt = B_DONE;
            end
            default: begin
              res_nxt = '0;
              err_nxt = 1'b1;
              state_nxt = B_DONE;
            end
          endcase
        end
      end
      B_DIV: begin
        rem_nxt = rem_step;
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          res_nxt = rem_step;
          err_nxt = 1'b0;
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt = res_r;
          out_tuser_nxt = err_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  a_rem_below_divisor: assert property (
    @(posedge clk) disable iff (!rst_n) state_r == B_DIV |-> rem_r < div_r)
    else $error("partial remainder not below the divisor");

  a_error_value_zero: assert property (
    @(posedge clk) disable iff (!rst_n) out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries a nonzero value");

  a_done_waits: assert property (
    @(posedge clk) disable iff (!rst_n)
    state_r == B_DONE && !out_free |=> state_r == B_DONE && $stable(res_r))
    else $error("finished result lost while the output was stalled");

endmodule

// ----- src/pcg32_bounded_random_unit.sv -----
// Top level of the PCG32 bounded random unit.
// Each input transaction is one draw request carrying a 64-bit limit; each yields one
// result transaction with the 32-bit XSH RR word reduced modulo the limit, or zero with
// the error flag set when the limit is zero. A draw with a limit below 2^32 goes to the
// bit-serial remainder unit: it takes the queued draw, runs 32 quotient steps, then moves
// the remainder into the output register. A zero limit or one of 2^32 or more needs no
// remainder. The front end steps the LCG through one shared 32x32 multiplier after each
// accepted draw and takes no new draw until that step is done. Writing the seed register
// while the front end is idle loads the generator state. Configuration must be written
// only while no draw is outstanding; the block itself does not enforce this.
module pcg32_bounded_random_unit
  import pbr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [LIMIT_W-1:0]    in_tdata,   // [63:0] limit
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [WORD_W-1:0]     out_tdata,  // [31:0] value
  output logic                  out_tuser   // [0] limit_error
);

  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  draw_entry_t push_entry;
  draw_entry_t head_entry;

  pbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  pbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (head_entry),
    .empty      (q_empty)
  );

  pbr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- verif/pcg32_draw_checker.sv -----
// Checker for the PCG32 bounded random unit: tracks configuration, predicts each draw and compares results.
module pcg32_draw_checker
  import pbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [LIMIT_W-1:0]    in_tdata,   // [63:0] limit
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [WORD_W-1:0]     out_tdata,  // [31:0] value
  input  logic                  out_tuser,  // [0] limit_error
  output int                    fail_count,
  output int                    pending_draws
);

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              limit_error;
  } draw_result_t;

  logic [STATE_W-1:0]    lcg_state;
  logic [CFG_DATA_W-1:0] step_incr;
  draw_result_t          expected_draws[$];

  function automatic logic [WORD_W-1:0] permuted_word(input logic [STATE_W-1:0] s);
    logic [WORD_W-1:0]   x;
    logic [2*WORD_W-1:0] doubled;
    logic [4:0]          rot;
    x = WORD_W'(((s >> XSH_SHIFT) ^ s) >> XSH_LO);
    rot = s[STATE_W-1:ROT_LO];
    doubled = {x, x} >> rot;
    return doubled[WORD_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    draw_result_t       got;
    draw_result_t       want;
    logic [LIMIT_W-1:0] remainder;
    if (!rst_n) begin
      lcg_state = '0;
      step_incr = '0;
      fail_count = 0;
      expected_draws.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SEED) begin
          lcg_state = cfg_wdata;
        end else if (cfg_index == REG_INCREMENT) begin
          step_incr = cfg_wdata;
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{value: out_tdata, limit_error: out_tuser};
        if (expected_draws.size() == 0) begin
          fail_count++;
          $error("result transaction with no draw outstanding: value %0h, limit_error %0b",
                 got.value, got.limit_error);
        end else begin
          want = expected_draws.pop_front();
          if (got.value !== want.value) begin
            fail_count++;
            $error("value: expected %0h, actual %0h", want.value, got.value);
          end
          if (got.limit_error !== want.limit_error) begin
            fail_count++;
            $error("limit_error: expected %0b, actual %0b", want.limit_error, got.limit_error);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tdata == '0) begin
          want = '{value: '0, limit_error: 1'b1};
        end else begin
          remainder = {{(LIMIT_W-WORD_W){1'b0}}, permuted_word(lcg_state)} % in_tdata;
          want = '{value: remainder[WORD_W-1:0], limit_error: 1'b0};
        end
        expected_draws.push_back(want);
        lcg_state = lcg_state * PCG_MULT + (step_incr | 64'd1);
      end
    end
    pending_draws <= expected_draws.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the PCG32 bounded random unit testbench: clock, reset, stimulus, flow control and verdict.
module testbench
  import pbr_pkg::*;
();

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [LIMIT_W-1:0]    in_tdata;   // [63:0] limit
  logic                  out_tvalid;
  logic                  out_tready;
  logic [WORD_W-1:0]     out_tdata;  // [31:0] value
  logic                  out_tuser;  // [0] limit_error

  int fail_count;
  int pending_draws;
  int results_taken;
  bit calm;

  logic [LIMIT_W-1:0] edge_limits[$];

  pcg32_bounded_random_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pcg32_draw_checker draw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_draws (pending_draws)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [LIMIT_W-1:0] pick_limit();
    logic [LIMIT_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return LIMIT_W'($urandom_range(16, 1));
      2, 3: return {32'd0, r[31:0]};
      4: return r;
      5: return 64'd1 << $urandom_range(63);
      6: return 64'hFFFF_FFFF - LIMIT_W'($urandom_range(3));
      7: return 64'h1_0000_0000 + LIMIT_W'($urandom_range(3));
      8: return {48'd0, r[15:0]};
      default: return LIMIT_W'($urandom_range(1000, 1));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic send_draw(input logic [LIMIT_W-1:0] lim);
    while (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= lim;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_draws != 0);
  endtask

  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    results_taken = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) results_taken++;
      if (!held && results_taken >= 500) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 25);
      end
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SEED;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    calm = 1'b0;
    edge_limits = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd7, 64'd10, 64'h7FFF_FFFF,
                    64'h8000_0000, 64'hFFFF_FFFE, 64'hFFFF_FFFF, 64'h1_0000_0000,
                    64'h1_0000_0001, 64'hFFFF_FFFF_0000_0000, 64'h8000_0000_0000_0000,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1, 64'h0000_0000_5555_5555};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (edge_limits[i]) send_draw(edge_limits[i]);
    in_tvalid <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_SEED, '0);
          write_reg(REG_INCREMENT, '0);
        end
        1: begin
          write_reg(REG_SEED, '1);
          write_reg(REG_INCREMENT, '1);
        end
        2: begin
          write_reg(REG_SEED, {$urandom, $urandom});
          write_reg(REG_INCREMENT, {$urandom, $urandom} & ~64'd1);
        end
        3: write_reg(REG_INCREMENT, {$urandom, $urandom});
        4: begin
          write_reg(REG_SEED, 64'h8000_0000_0000_0000);
          write_reg(REG_INCREMENT, 64'd1);
        end
        6: write_reg(REG_SEED, {$urandom, $urandom});
        default: begin
          write_reg(REG_INCREMENT, {$urandom, $urandom});
          write_reg(REG_SEED, {$urandom, $urandom});
        end
      endcase
      cfg_we <= 1'b0;
      calm = (p == 3);
      repeat (205) send_draw(pick_limit());
      in_tvalid <= 1'b0;
    end
    calm = 1'b0;

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_draws == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pbr_pkg.sv
src/pbr_front.sv
src/pbr_queue.sv
src/pbr_back.sv
src/pcg32_bounded_random_unit.sv
verif/pcg32_draw_checker.sv
verif/testbench.sv
